/* design/sfd4_pkg.sv */
// Shared types and constants for the staggered-grid 4th-order point update.
// No dependencies.
`timescale 1ns / 1ps

package sfd4_pkg;

	localparam int WORD_W       = 32;	// Q8.24 value width
	localparam int COEF_W       = 31;	// unsigned coefficient width
	localparam int ACC_W        = 40;	// axis accumulator width
	localparam int CMD_W        = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int FRAC_BITS_DEF = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_VEL  = 2'd0,	// velocity point, one result
		CMD_PART = 2'd1,	// pressure axis partial, accumulate only
		CMD_LAST = 2'd2,	// pressure last axis, one result
		CMD_NONE = 2'd3	// unused, dropped
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER = 1'd0,
		REG_OUTER = 1'd1
	} reg_idx_t;

	localparam logic signed [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  S40_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  S40_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

/* design/sfd4_mul.sv */
// Shared 32x32 signed multiplier with registered product and round-to-nearest
// on the registered product. Depends on sfd4_pkg.
`timescale 1ns / 1ps

module sfd4_mul #(
	parameter int FRAC_BITS = sfd4_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [sfd4_pkg::WORD_W-1:0]     a,
	input  logic signed [sfd4_pkg::WORD_W-1:0]     b,
	output logic signed [2*sfd4_pkg::WORD_W-FRAC_BITS-1:0] rnd
);
	import sfd4_pkg::*;

	localparam int PROD_W = 2 * WORD_W;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] biased;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	// |prod| <= 2^62, so adding half an LSB cannot wrap
	assign biased = prod_q + HALF;
	assign rnd    = biased[PROD_W-1:FRAC_BITS];

endmodule

/* design/staggered_grid_fd4_update_top.sv */
// Top level of the staggered-grid 4th-order point update: handshakes, weight
// registers, sequencer and saturating datapath. Depends on sfd4_pkg, sfd4_mul.
`timescale 1ns / 1ps

//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//  in      | in_valid in_ready cmd old_value coef      | in
//          | near_high near_low far_high far_low       |
//  out     | out_valid out_ready new_value saturated   | out
//
// One multiplier is shared by three dependent products (inner weight, outer
// weight, coefficient); the sequencer walks through them in order.
// Velocity goes MUL_IN, MUL_OUT, TERM, MUL_CO, UPD; pressure partial ends in
// ACC after TERM, pressure last goes ACC, MUL_CO, UPD; unused stays in IDLE.
// in_ready is high only while the sequencer is idle. A finished word sits in
// the output register; the next item is taken meanwhile, and the sequencer
// holds its final step only if that register is still full.
// Reset clears the sequencer, the accumulator, its flag and the output valid,
// and loads the default weights 9/8 and -1/24. cfg_ready is always high.

module staggered_grid_fd4_update_top #(
	parameter int FRAC_BITS = sfd4_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sfd4_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sfd4_pkg::WORD_W-1:0]           cfg_data,
	// input words
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [sfd4_pkg::CMD_W-1:0]            cmd,
	input  logic signed [sfd4_pkg::WORD_W-1:0]    old_value,
	input  logic [sfd4_pkg::COEF_W-1:0]           coef,
	input  logic signed [sfd4_pkg::WORD_W-1:0]    near_high,
	input  logic signed [sfd4_pkg::WORD_W-1:0]    near_low,
	input  logic signed [sfd4_pkg::WORD_W-1:0]    far_high,
	input  logic signed [sfd4_pkg::WORD_W-1:0]    far_low,
	// result words
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [sfd4_pkg::WORD_W-1:0]    new_value,
	output logic                                  saturated
);
	import sfd4_pkg::*;

	localparam int RND_W = 2 * WORD_W - FRAC_BITS;	// rounded product width
	localparam int EXT_W = RND_W + 1;
	localparam longint INNER_RST_L = longint'(9) <<< (FRAC_BITS - 3);
	localparam longint OUTER_RST_L = -(((longint'(1) <<< FRAC_BITS) + 12) / 24);
	localparam logic signed [WORD_W-1:0] INNER_RST = WORD_W'(INNER_RST_L);
	localparam logic signed [WORD_W-1:0] OUTER_RST = WORD_W'(OUTER_RST_L);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_IN,	// inner weight * near difference
		ST_MUL_OUT,	// outer weight * far difference
		ST_TERM,	// sum of rounded products, saturated
		ST_ACC,		// pressure accumulate
		ST_MUL_CO,	// coefficient * term or total
		ST_UPD		// old - rounded product, saturated, to output register
	} state_t;

	state_t                      state_q;
	logic signed [WORD_W-1:0]    inner_q, outer_q;
	logic signed [ACC_W-1:0]     axis_sum_q;
	logic                        sum_sat_q;
	cmd_t                        cmd_q;
	logic signed [WORD_W-1:0]    old_q;
	logic [COEF_W-1:0]           coef_q;
	logic signed [WORD_W-1:0]    dn_q, df_q;
	logic signed [RND_W-1:0]     r1_q;
	logic signed [WORD_W-1:0]    x_q;	// term, later the multiplicand of coef
	logic                        flag_q;
	logic                        out_valid_q;
	logic signed [WORD_W-1:0]    new_value_q;
	logic                        saturated_q;

	// shared multiplier
	logic                        mul_en;
	logic signed [WORD_W-1:0]    mul_a, mul_b;
	logic signed [RND_W-1:0]     rnd;

	sfd4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.rnd (rnd)
	);

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_MUL_IN: begin
				mul_en = 1'b1;
				mul_a  = inner_q;
				mul_b  = dn_q;
			end
			ST_MUL_OUT: begin
				mul_en = 1'b1;
				mul_a  = outer_q;
				mul_b  = df_q;
			end
			ST_MUL_CO: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, coef_q};
				mul_b  = x_q;
			end
			default: begin
			end
		endcase
	end

	// neighbor differences, exact in 33 bits, then saturated
	logic signed [WORD_W:0]      dn_w, df_w;
	logic signed [WORD_W-1:0]    dn_s, df_s;
	logic                        dn_ov, df_ov;

	assign dn_w  = {near_high[WORD_W-1], near_high} - {near_low[WORD_W-1], near_low};
	assign df_w  = {far_high[WORD_W-1], far_high} - {far_low[WORD_W-1], far_low};
	assign dn_ov = dn_w[WORD_W] != dn_w[WORD_W-1];
	assign df_ov = df_w[WORD_W] != df_w[WORD_W-1];
	assign dn_s  = dn_ov ? (dn_w[WORD_W] ? S32_MIN : S32_MAX) : dn_w[WORD_W-1:0];
	assign df_s  = df_ov ? (df_w[WORD_W] ? S32_MIN : S32_MAX) : df_w[WORD_W-1:0];

	// term: sum of the two rounded products
	logic signed [EXT_W-1:0]     t_w;
	logic                        t_ov;
	logic signed [WORD_W-1:0]    t_s;

	assign t_w  = {r1_q[RND_W-1], r1_q} + {rnd[RND_W-1], rnd};
	assign t_ov = t_w[EXT_W-1:WORD_W-1] != {(EXT_W-WORD_W+1){t_w[EXT_W-1]}};
	assign t_s  = t_ov ? (t_w[EXT_W-1] ? S32_MIN : S32_MAX) : t_w[WORD_W-1:0];

	// accumulate into 40 bits, then narrow to 32 for the last axis
	logic signed [ACC_W:0]       a_w;
	logic                        a_ov;
	logic signed [ACC_W-1:0]     a_s;
	logic                        n_ov;
	logic signed [WORD_W-1:0]    n_s;

	assign a_w  = {axis_sum_q[ACC_W-1], axis_sum_q}
	            + {{(ACC_W-WORD_W+1){x_q[WORD_W-1]}}, x_q};
	assign a_ov = a_w[ACC_W] != a_w[ACC_W-1];
	assign a_s  = a_ov ? (a_w[ACC_W] ? S40_MIN : S40_MAX) : a_w[ACC_W-1:0];
	assign n_ov = a_s[ACC_W-1:WORD_W-1] != {(ACC_W-WORD_W+1){a_s[ACC_W-1]}};
	assign n_s  = n_ov ? (a_s[ACC_W-1] ? S32_MIN : S32_MAX) : a_s[WORD_W-1:0];

	// update: old - rounded coefficient product
	logic signed [EXT_W-1:0]     u_w;
	logic                        u_ov;
	logic signed [WORD_W-1:0]    u_s;

	assign u_w  = {{(EXT_W-WORD_W){old_q[WORD_W-1]}}, old_q} - {rnd[RND_W-1], rnd};
	assign u_ov = u_w[EXT_W-1:WORD_W-1] != {(EXT_W-WORD_W+1){u_w[EXT_W-1]}};
	assign u_s  = u_ov ? (u_w[EXT_W-1] ? S32_MIN : S32_MAX) : u_w[WORD_W-1:0];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign new_value = new_value_q;
	assign saturated = saturated_q;

	// weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= INNER_RST;
			outer_q <= OUTER_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INNER: inner_q <= cfg_data;
				REG_OUTER: outer_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			old_q  <= old_value;
			coef_q <= coef;
			dn_q   <= dn_s;
			df_q   <= df_s;
		end
		if (state_q == ST_MUL_OUT) begin
			r1_q <= rnd;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_NONE;
			axis_sum_q  <= '0;
			sum_sat_q   <= 1'b0;
			x_q         <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			new_value_q <= '0;
			saturated_q <= 1'b0;
		end else begin
			// in ST_UPD the output register is handled by the state itself
			if (out_valid_q && out_ready && state_q != ST_UPD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && cmd_t'(cmd) != CMD_NONE) begin
						cmd_q   <= cmd_t'(cmd);
						flag_q  <= dn_ov | df_ov;
						state_q <= ST_MUL_IN;
					end
				end
				ST_MUL_IN:  state_q <= ST_MUL_OUT;
				ST_MUL_OUT: state_q <= ST_TERM;
				ST_TERM: begin
					x_q    <= t_s;
					flag_q <= flag_q | t_ov;
					state_q <= (cmd_q == CMD_VEL) ? ST_MUL_CO : ST_ACC;
				end
				ST_ACC: begin
					if (cmd_q == CMD_PART) begin
						axis_sum_q <= a_s;
						sum_sat_q  <= sum_sat_q | flag_q | a_ov;
						state_q    <= ST_IDLE;
					end else begin
						x_q        <= n_s;
						flag_q     <= flag_q | a_ov | n_ov | sum_sat_q;
						axis_sum_q <= '0;
						sum_sat_q  <= 1'b0;
						state_q    <= ST_MUL_CO;
					end
				end
				ST_MUL_CO: state_q <= ST_UPD;
				ST_UPD: begin
					// hold here while the previous word is still unread
					if (!out_valid_q || out_ready) begin
						new_value_q <= u_s;
						saturated_q <= flag_q | u_ov;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* tb/tb_staggered_grid_fd4_update_top.sv */
// Testbench for staggered_grid_fd4_update_top: directed and random stencil words checked
// against a scoreboard holding its own Q8.24 model of the point update.
// Depends on sfd4_pkg and the design; reads no files.
`timescale 1ns / 1ps

module tb_staggered_grid_fd4_update_top;

	import sfd4_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;

	// Q8.24 corners and handy stencil values
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_ONE = 32'h0100_0000;
	localparam logic [31:0] Q_BIG = 32'h7000_0000;	// 9/8 of this still fits in 32 bits
	localparam logic [30:0] C_MAX = 31'h7FFF_FFFF;
	localparam logic [30:0] C_ONE = 31'h0100_0000;

	// weights after reset: 9/8 and -1/24 rounded to nearest
	localparam logic [31:0] W_INNER_DEF = 32'(9 << (FRAC - 3));
	localparam logic [31:0] W_OUTER_DEF = 32'(-(((1 << FRAC) + 12) / 24));

	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam longint S40_HI = 64'sd549755813887;
	localparam longint S40_LO = -64'sd549755813888;

	localparam int LONG_HOLD      = 400;	// receiver hold-off, fills the pipe
	localparam int SETTLE_CYCLES  = 12;	// lets a trailing partial axis reach idle
	localparam int WATCHDOG_LIMIT = 5000;	// hold-off plus sender gaps, many times over

	typedef struct {
		cmd_t               op;
		logic signed [31:0] old_value;
		logic [30:0]        coef;
		logic signed [31:0] near_high;
		logic signed [31:0] near_low;
		logic signed [31:0] far_high;
		logic signed [31:0] far_low;
	} grid_word_t;

	typedef struct {
		logic [31:0] value;
		bit          sat;
	} point_result_t;

	// Scoreboard: runs the point update on every accepted word but unused
	// commands, and keeps the expected results in arrival order.
	class fd4_scoreboard;
		logic signed [31:0] inner_w;
		logic signed [31:0] outer_w;
		longint             axis_acc;
		bit                 acc_sat;
		bit                 step_sat;
		point_result_t      expected_q[$];
		int                 errors;
		int                 results_seen;

		function new();
			inner_w = W_INNER_DEF;
			outer_w = W_OUTER_DEF;
			axis_acc = 0;
			acc_sat = 0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void write_weight(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_INNER: inner_w = data;
				REG_OUTER: outer_w = data;
			endcase
		endfunction

		function longint clip(longint x, longint lo, longint hi);
			if (x > hi) begin
				step_sat = 1'b1;
				return hi;
			end
			if (x < lo) begin
				step_sat = 1'b1;
				return lo;
			end
			return x;
		endfunction

		// round half up, then drop the fraction
		function longint round_q(longint x);
			longint y;
			y = x + (64'sd1 <<< (FRAC - 1));
			return y >>> FRAC;
		endfunction

		function longint stencil(grid_word_t w);
			longint dn;
			longint df;
			dn = clip(longint'(w.near_high) - longint'(w.near_low), S32_LO, S32_HI);
			df = clip(longint'(w.far_high) - longint'(w.far_low), S32_LO, S32_HI);
			return clip(round_q(longint'(inner_w) * dn) + round_q(longint'(outer_w) * df),
				S32_LO, S32_HI);
		endfunction

		function logic [31:0] update(grid_word_t w, longint x);
			longint c;
			c = longint'(w.coef);
			return 32'(clip(longint'(w.old_value) - round_q(c * x), S32_LO, S32_HI));
		endfunction

		function void note_input(grid_word_t w);
			longint term;
			longint total;
			point_result_t r;
			if (w.op == CMD_NONE)
				return;
			step_sat = 1'b0;
			term = stencil(w);
			if (w.op == CMD_VEL) begin
				r.value = update(w, term);
				r.sat = step_sat;
				expected_q.push_back(r);
				return;
			end
			total = clip(axis_acc + term, S40_LO, S40_HI);
			if (w.op == CMD_PART) begin
				axis_acc = total;
				acc_sat |= step_sat;
				return;
			end
			// last pressure axis: fold in the stored flag, narrow, update, clear
			step_sat |= acc_sat;
			total = clip(total, S32_LO, S32_HI);
			r.value = update(w, total);
			r.sat = step_sat;
			axis_acc = 0;
			acc_sat = 0;
			expected_q.push_back(r);
		endfunction

		function void report(string what, logic [31:0] exp_v, bit exp_s,
			logic [31:0] got_v, logic got_s);
			errors++;
			if (errors <= 10)
				$display("[%0t] result %0d: %s: expected value %h sat %b, got value %h sat %b",
					$time, results_seen, what, exp_v, exp_s, got_v, got_s);
		endfunction

		function void check_result(logic [31:0] value, logic sat);
			point_result_t e;
			if (expected_q.size() == 0) begin
				report("word with nothing expected", 'x, 1'b0, value, sat);
				results_seen++;
				return;
			end
			e = expected_q.pop_front();
			if (value !== e.value)
				report("new_value mismatch", e.value, e.sat, value, sat);
			if (sat !== e.sat)
				report("saturated mismatch", e.value, e.sat, value, sat);
			results_seen++;
		endfunction

		function void flush_leftover();
			if (expected_q.size() != 0) begin
				$display("%0d expected words never arrived", expected_q.size());
				errors += expected_q.size();
			end
		endfunction

		function int pending_count();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd       = '0;
	logic signed [31:0]   old_value = '0;
	logic [COEF_W-1:0]    coef      = '0;
	logic signed [31:0]   near_high = '0;
	logic signed [31:0]   near_low  = '0;
	logic signed [31:0]   far_high  = '0;
	logic signed [31:0]   far_low   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [31:0]   new_value;
	logic                 saturated;

	staggered_grid_fd4_update_top u_dut (.*);

	fd4_scoreboard sb;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Result side: stall pattern, long hold-off on request, checking.
	// All sampling happens at the edge, before the design's updates land.
	// ------------------------------------------------------------------
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int pat_period = 1;
	int pat_busy = 0;
	int pat_pos = 0;
	int pat_left = 0;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(new_value, saturated);
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			// long stall: the block fills up and must drop in_ready
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			// a fresh duty pattern when the last one runs out; at least a quarter of them never stall
			if (pat_left == 0) begin
				pat_period = $urandom_range(1, 9);
				pat_busy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, pat_period - 1);
				pat_left = $urandom_range(40, 300);
				pat_pos = 0;
			end
			out_ready <= (pat_pos % pat_period) >= pat_busy;
			pat_pos++;
			pat_left--;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: a run of cycles in which no word moves on any channel
	// ------------------------------------------------------------------
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", stuck_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	int burst_left = 0;

	function automatic grid_word_t pack_word(cmd_t op, logic [31:0] ov, logic [30:0] cf,
		logic [31:0] nh, logic [31:0] nl, logic [31:0] fh, logic [31:0] fl);
		grid_word_t w;
		w.op = op;
		w.old_value = ov;
		w.coef = cf;
		w.near_high = nh;
		w.near_low = nl;
		w.far_high = fh;
		w.far_low = fl;
		return w;
	endfunction

	// mix of full-range, small, mid-size and corner values
	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0, 1: return $urandom();
			2: return $urandom_range(0, 1 << 27) - (1 << 26);
			3: return $urandom_range(0, 1 << 21) - (1 << 20);
			4: return $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 6);
			default: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'h0;
					3: return 32'hFFFF_FFFF;
					default: return Q_ONE;
				endcase
			end
		endcase
	endfunction

	function automatic logic [30:0] rand_coef();
		case ($urandom_range(0, 5))
			0, 1: return 31'($urandom());
			2: return 31'($urandom_range(0, 1 << 25));
			3: return 31'($urandom_range(0, 1 << 24));
			4: return C_MAX;
			default: return 31'h0;
		endcase
	endfunction

	function automatic grid_word_t rand_word(cmd_t op);
		return pack_word(op, rand_q(), rand_coef(), rand_q(), rand_q(), rand_q(), rand_q());
	endfunction

	// Offer one word; bursts of random length separated by random gaps,
	// now and then a long burst with no gaps at all.
	task automatic send_word(input grid_word_t w);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 16);
		end
		burst_left--;
		in_valid  <= 1'b1;
		cmd       <= w.op;
		old_value <= w.old_value;
		coef      <= w.coef;
		near_high <= w.near_high;
		near_low  <= w.near_low;
		far_high  <= w.far_high;
		far_low   <= w.far_low;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
	endtask

	task automatic write_weights(input logic [31:0] inner, input logic [31:0] outer);
		cfg_valid <= 1'b1;
		cfg_index <= REG_INNER;
		cfg_data  <= inner;
		do @(posedge clk); while (!cfg_ready);
		sb.write_weight(REG_INNER, inner);
		cfg_index <= REG_OUTER;
		cfg_data  <= outer;
		do @(posedge clk); while (!cfg_ready);
		sb.write_weight(REG_OUTER, outer);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every expected word, then give a trailing
	// partial-axis word time to retire before touching the weights.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed sequences: velocity points and pressure groups of
	// partial axes closed by a last axis. Some unused commands and stray
	// partial axes as noise; unused commands do not count.
	task automatic run_random(input int n_words);
		int done;
		int pick;
		int parts;
		done = 0;
		while (done < n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_word(rand_word(CMD_VEL));
				done++;
			end else if (pick < 85) begin
				parts = $urandom_range(0, 3);
				repeat (parts) send_word(rand_word(CMD_PART));
				send_word(rand_word(CMD_LAST));
				done += parts + 1;
			end else if (pick < 93) begin
				send_word(rand_word(CMD_NONE));
			end else begin
				send_word(rand_word(CMD_PART));
				done++;
			end
		end
	endtask

	// Drive the 40-bit accumulator past its rail with unflagged terms, then
	// pull it back so the clamped total lands in 32-bit range and shows in
	// the result. Needs the reset weights.
	task automatic overflow_run(input bit downward);
		grid_word_t push_w;
		grid_word_t pull_w;
		push_w = pack_word(CMD_PART, 32'h0, rand_coef(),
			downward ? 32'h0 : Q_BIG, downward ? Q_BIG : 32'h0, 32'h0, 32'h0);
		pull_w = pack_word(CMD_PART, 32'h0, rand_coef(),
			downward ? Q_BIG : 32'h0, downward ? 32'h0 : Q_BIG, 32'h0, 32'h0);
		repeat ($urandom_range(262, 272)) send_word(push_w);
		repeat (260) send_word(pull_w);
		send_word(pack_word(CMD_LAST, rand_q(), rand_coef(), 32'h0, 32'h0, 32'h0, 32'h0));
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words on the reset weights
		send_word(pack_word(CMD_VEL, 32'h0, 31'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, 5 * Q_ONE, C_ONE, Q_ONE, 32'h0, 2 * Q_ONE, 32'hFF00_0000));
		// near and far differences past the 32-bit rails, both signs
		send_word(pack_word(CMD_VEL, Q_ONE, C_ONE, Q_MAX, Q_MIN, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, Q_ONE, C_ONE, Q_MIN, Q_MAX, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, 32'h0, C_ONE, 32'h0, 32'h0, Q_MAX, Q_MIN));
		send_word(pack_word(CMD_VEL, 32'h0, C_ONE, 32'h0, 32'h0, Q_MIN, Q_MAX));
		// term clamps and the update overflows high; the update alone overflows low
		send_word(pack_word(CMD_VEL, Q_MAX, C_MAX, Q_MIN, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, Q_MIN, C_MAX, Q_BIG, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, 32'h1234_5678, C_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
		// exact halves: 9/8 of +4 and -4 ulp
		send_word(pack_word(CMD_VEL, 32'h0, C_ONE, 32'd4, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, 32'h0, C_ONE, 32'h0, 32'd4, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, Q_ONE, 31'h0080_0000, 32'h0, 32'h0, 32'h1800_0000, 32'h0));
		// unused command: dropped, no result, accumulator untouched
		send_word(pack_word(CMD_NONE, Q_MAX, C_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
		// saturation on a partial axis carries into the last axis only
		send_word(pack_word(CMD_PART, 32'h0, 31'h0, Q_MAX, Q_MIN, 32'h0, 32'h0));
		send_word(pack_word(CMD_LAST, Q_ONE, C_ONE, 32'h0, 32'h0, Q_ONE, 32'h0));
		send_word(pack_word(CMD_LAST, Q_ONE, C_ONE, Q_ONE, 32'h0, 32'h0, 32'h0));
		// accumulated total beyond 32 bits: narrowed before the coefficient
		send_word(pack_word(CMD_PART, 32'h0, 31'h0, Q_BIG, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_PART, 32'h0, 31'h0, Q_BIG, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_LAST, 32'h0, C_ONE, 32'h0, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_PART, 32'h0, 31'h0, 32'h0, Q_BIG, 32'h0, 32'h0));
		send_word(pack_word(CMD_PART, 32'h0, 31'h0, 32'h0, Q_BIG, 32'h0, 32'h0));
		send_word(pack_word(CMD_LAST, Q_MAX, C_ONE, 32'h0, 32'h0, 32'h0, 32'h0));
		send_word(pack_word(CMD_VEL, 32'hFFFF_FFFF, C_MAX, 32'hFFFF_FFFF, 32'h0,
			32'hFFFF_FFFF, 32'h0));
		send_word(pack_word(CMD_VEL, Q_MIN, 31'h0, Q_MIN, Q_MAX, Q_MAX, Q_MIN));

		// 40-bit accumulator rail, both directions
		overflow_run(1'b0);
		overflow_run(1'b1);

		// random phases, each on its own weight setting; the first one
		// also holds the receiver off for a long stretch
		settle();
		write_weights($urandom_range(0, 8 << 24) - (4 << 24),
			$urandom_range(0, 8 << 24) - (4 << 24));
		hold_req <= hold_req + 1;
		run_random(120);

		settle();
		write_weights(Q_MAX, Q_MIN);
		run_random(100);

		settle();
		write_weights(Q_MIN, Q_MAX);
		run_random(100);

		settle();
		write_weights($urandom(), $urandom());
		run_random(80);

		settle();
		write_weights(32'h0, 32'h0);
		run_random(40);

		settle();
		write_weights(W_INNER_DEF, W_OUTER_DEF);
		run_random(160);

		// drain and close out
		settle();
		sb.flush_leftover();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
